// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/rtt_pkg.sv
// shared types and constants of the round-trip statistics unit
package rtt_pkg;
    localparam int MaxSamples = 12;
    localparam logic [7:0] LostMax = 8'd255;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_LOST  = 2'd1,
        OP_REPORT = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SORT, ST_DIVJ, ST_DIVL, ST_OUT
    } t_state;

    typedef struct packed {
        logic do_add;
        logic do_lost;
        logic do_clear;
        logic start_scan;
        logic scan_step;
        logic sort_step;
        logic start_div_j;
        logic start_div_l;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic sort_done;
        logic div_done;
    } t_status;

    function automatic logic [1:0] ci_rank(input logic [3:0] n);
        logic [1:0] r;
        begin
            r = 2'd0;
            if (n >= 4'd5) r = 2'd1;
            if (n >= 4'd8) r = 2'd2;
            if (n >= 4'd11) r = 2'd3;
            return r;
        end
    endfunction
endpackage

// File: hw/rtl/rtt_ctrl.sv
// sequencing state machine of the round-trip statistics unit
`include "assert_macros.svh"
module rtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_operation,
    input  logic             i_out_busy,
    input  rtt_pkg::t_status i_status,
    output logic             o_stall,
    output rtt_pkg::t_cmd    o_cmd
);
    rtt_pkg::t_state r_state, n_state;
    logic            w_acc;

    assign o_stall = (r_state != rtt_pkg::ST_IDLE);
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rtt_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtt_pkg::ST_IDLE: if (w_acc && i_operation == rtt_pkg::OP_REPORT)
                n_state = rtt_pkg::ST_SCAN;
            rtt_pkg::ST_SCAN: if (i_status.scan_done) n_state = rtt_pkg::ST_SORT;
            rtt_pkg::ST_SORT: if (i_status.sort_done) n_state = rtt_pkg::ST_DIVJ;
            rtt_pkg::ST_DIVJ: if (i_status.div_done) n_state = rtt_pkg::ST_DIVL;
            rtt_pkg::ST_DIVL: if (i_status.div_done && !i_out_busy)
                n_state = rtt_pkg::ST_OUT;
            rtt_pkg::ST_OUT: n_state = rtt_pkg::ST_IDLE;
            default: n_state = rtt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            rtt_pkg::ST_IDLE: begin
                o_cmd.do_add     = w_acc && i_operation == rtt_pkg::OP_ADD;
                o_cmd.do_lost    = w_acc && i_operation == rtt_pkg::OP_LOST;
                o_cmd.do_clear   = w_acc && i_operation == rtt_pkg::OP_CLEAR;
                o_cmd.start_scan = w_acc && i_operation == rtt_pkg::OP_REPORT;
            end
            rtt_pkg::ST_SCAN: begin
                o_cmd.scan_step   = 1'b1;
                o_cmd.start_div_j = i_status.scan_done;
            end
            rtt_pkg::ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.div_step  = 1'b1;
            end
            rtt_pkg::ST_DIVJ: begin
                o_cmd.div_step    = !i_status.div_done;
                o_cmd.start_div_l = i_status.div_done;
            end
            rtt_pkg::ST_DIVL: o_cmd.div_step = !i_status.div_done;
            rtt_pkg::ST_OUT: o_cmd.load_out = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    `ASSERT_IMPL(a_out_from_divl, i_clk, i_rst_n,
        r_state == rtt_pkg::ST_OUT |-> $past(r_state) == rtt_pkg::ST_DIVL, "bad path")
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n,
        r_state != rtt_pkg::ST_IDLE |-> o_stall, "accepted while busy")
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n,
        o_cmd.load_out |-> !i_out_busy, "overwrote result")
endmodule

// File: hw/rtl/rtt_dpath.sv
// sample store, scan, sorter and shared divider
`include "assert_macros.svh"
module rtt_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rtt_pkg::t_cmd    i_cmd,
    input  logic [31:0]      i_rtt_sample,
    input  logic             i_out_stall,
    output rtt_pkg::t_status o_status,
    output logic             o_out_busy,
    output logic             o_valid,
    output logic [3:0]       o_sample_total,
    output logic [31:0]      o_min_rtt,
    output logic [31:0]      o_median_rtt,
    output logic [31:0]      o_p90_rtt,
    output logic [31:0]      o_jitter_mean,
    output logic [6:0]       o_loss_percent,
    output logic             o_ci_valid,
    output logic [31:0]      o_ci_low,
    output logic [31:0]      o_ci_high
);
    logic [31:0] r_store [rtt_pkg::MaxSamples];
    logic [31:0] r_sort  [rtt_pkg::MaxSamples];
    logic [3:0]  r_cnt;
    logic [7:0]  r_lost;
    logic [3:0]  r_idx;
    logic [31:0] r_min;
    logic [35:0] r_jsum;
    logic [31:0] r_prev;
    logic [3:0]  r_pass;
    logic        r_phase;
    // divider: 36-bit dividend, up to 9-bit divisor
    logic [35:0] r_quo;
    logic [8:0]  r_rem;
    logic [8:0]  r_den;
    logic [5:0]  r_dcnt;
    logic [31:0] r_jit;
    logic        r_valid;
    logic [31:0] w_cur;
    logic [31:0] w_diff;
    logic [9:0]  w_trial;
    logic [8:0]  w_tot;
    logic [3:0]  w_mid;
    logic [3:0]  w_p90;
    logic [1:0]  w_k;
    logic [32:0] w_msum;
    logic [7:0]  w_p9;

    assign w_cur  = r_store[r_idx];
    assign w_diff = (r_prev > w_cur) ? r_prev - w_cur : w_cur - r_prev;
    assign w_tot  = {5'd0, r_cnt} + {1'b0, r_lost};
    assign w_trial = {r_rem, r_quo[35]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_lost <= '0;
        end else begin
            if (i_cmd.do_add && r_cnt < 4'(rtt_pkg::MaxSamples)) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (i_cmd.do_lost && r_lost != rtt_pkg::LostMax) r_lost <= r_lost + 8'd1;
            if (i_cmd.do_clear) begin
                r_cnt  <= '0;
                r_lost <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_add && r_cnt < 4'(rtt_pkg::MaxSamples)) r_store[r_cnt] <= i_rtt_sample;
    end

    // scan pass: minimum non-zero sample and jitter sum, one sample a cycle, copies into sorter
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_idx  <= '0;
            r_min  <= '0;
            r_jsum <= '0;
        end else if (i_cmd.scan_step && r_idx < r_cnt) begin
            r_sort[r_idx] <= w_cur;
            if (w_cur != 32'd0 && (r_min == 32'd0 || w_cur < r_min)) r_min <= w_cur;
            if (r_idx != 4'd0) r_jsum <= r_jsum + {4'd0, w_diff};
            r_prev <= w_cur;
            r_idx  <= r_idx + 4'd1;
        end else if (i_cmd.sort_step) begin
            // odd-even transposition: one compare-exchange phase per cycle
            for (int i = 0; i < rtt_pkg::MaxSamples - 1; i++) begin
                if ((i % 2) == int'(r_phase) && 4'(i + 1) < r_cnt
                    && r_sort[i] > r_sort[i + 1]) begin
                    r_sort[i]     <= r_sort[i + 1];
                    r_sort[i + 1] <= r_sort[i];
                end
            end
        end
    end

    assign o_status.scan_done = i_cmd.scan_step && r_idx >= r_cnt;
    assign o_status.sort_done = r_pass == 4'(rtt_pkg::MaxSamples - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div_j) begin
            r_pass  <= '0;
            r_phase <= 1'b0;
        end else if (i_cmd.sort_step) begin
            r_pass  <= r_pass + 4'd1;
            r_phase <= ~r_phase;
        end
    end

    assign w_p9 = {4'd0, r_cnt} * 8'd9 - 8'd1;
    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div_j) begin
            r_quo  <= (r_cnt >= 4'd2) ? r_jsum : 36'd0;
            r_den  <= (r_cnt >= 4'd2) ? {5'd0, r_cnt - 4'd1} : 9'd1;
            r_rem  <= '0;
            r_dcnt <= 6'd36;
        end else if (i_cmd.start_div_l) begin
            r_jit  <= r_quo[31:0];
            r_quo  <= (w_tot == 9'd0) ? 36'd100 : {28'd0, r_lost} * 36'd100;
            r_den  <= (w_tot == 9'd0) ? 9'd1 : w_tot;
            r_rem  <= '0;
            r_dcnt <= 6'd36;
        end else if (i_cmd.div_step && r_dcnt != 6'd0) begin
            if (!w_trial[9]) r_rem <= w_trial[8:0];
            else r_rem <= {r_rem[7:0], r_quo[35]};
            r_quo  <= {r_quo[34:0], !w_trial[9]};
            r_dcnt <= r_dcnt - 6'd1;
        end
    end
    assign o_status.div_done = r_dcnt == 6'd0;

    // p90 index (9n-1)/10 for n up to 12 fits a small compare
    always_comb begin
        w_p90 = 4'd0;
        for (int t = 1; t < rtt_pkg::MaxSamples; t++) begin
            if ({1'b0, w_p9} >= 9'(10 * t)) w_p90 = 4'(t);
        end
    end
    assign w_mid  = r_cnt >> 1;
    assign w_k    = rtt_pkg::ci_rank(r_cnt);
    assign w_msum = {1'b0, r_sort[w_mid - 4'd1]} + {1'b0, r_sort[w_mid]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_cmd.load_out) r_valid <= 1'b1;
        else if (!i_out_stall) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_sample_total <= r_cnt;
            o_min_rtt      <= r_min;
            o_jitter_mean  <= r_jit;
            o_loss_percent <= r_quo[6:0];
            if (r_cnt == 4'd0) begin
                o_median_rtt <= '0;
                o_p90_rtt    <= '0;
            end else begin
                o_median_rtt <= r_cnt[0] ? r_sort[w_mid] : w_msum[32:1];
                o_p90_rtt    <= r_sort[w_p90];
            end
            o_ci_valid <= r_cnt >= 4'd5;
            o_ci_low   <= (r_cnt >= 4'd5) ? r_sort[{2'd0, w_k} - 4'd1] : 32'd0;
            o_ci_high  <= (r_cnt >= 4'd5) ? r_sort[r_cnt - {2'd0, w_k}] : 32'd0;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_busy = r_valid && i_out_stall;

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n,
        r_cnt <= 4'(rtt_pkg::MaxSamples), "count overflow")
    `ASSERT_IMPL(a_loss_range, i_clk, i_rst_n,
        o_valid |-> o_loss_percent <= 7'd100, "loss above 100")
    `ASSERT_IMPL(a_ci_zero, i_clk, i_rst_n,
        o_valid && !o_ci_valid |-> o_ci_low == 32'd0 && o_ci_high == 32'd0, "ci not zero")
endmodule

// File: hw/rtl/rtt_sample_statistics_unit.sv
// top level of the round-trip sample statistics unit
// Add, lost-probe and clear transfers are accepted without stalling the input. A
// report transfer stalls the input through a scan of the stored samples,
// twelve odd-even sort phases, the rest of the 36-step jitter quotient of the
// shared one-bit-per-cycle divider (it starts under the sort), the loss
// quotient, and the load of the result register. The loss pass also holds while
// an earlier result still waits in the stalled result register.
module rtt_sample_statistics_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_rtt_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_sample_total,
    output logic [31:0] o_min_rtt,
    output logic [31:0] o_median_rtt,
    output logic [31:0] o_p90_rtt,
    output logic [31:0] o_jitter_mean,
    output logic [6:0]  o_loss_percent,
    output logic        o_ci_valid,
    output logic [31:0] o_ci_low,
    output logic [31:0] o_ci_high
);
    rtt_pkg::t_cmd    w_cmd;
    rtt_pkg::t_status w_status;
    logic             w_busy;

    rtt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_operation(i_operation), .i_out_busy(w_busy), .i_status(w_status),
        .o_stall(o_stall), .o_cmd(w_cmd)
    );

    rtt_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_rtt_sample(i_rtt_sample),
        .i_out_stall(i_stall), .o_status(w_status), .o_out_busy(w_busy),
        .o_valid(o_valid), .o_sample_total(o_sample_total), .o_min_rtt(o_min_rtt),
        .o_median_rtt(o_median_rtt), .o_p90_rtt(o_p90_rtt),
        .o_jitter_mean(o_jitter_mean), .o_loss_percent(o_loss_percent),
        .o_ci_valid(o_ci_valid), .o_ci_low(o_ci_low), .o_ci_high(o_ci_high)
    );
endmodule
